/* rtl/txcw_pkg.sv */
// Package for the text console writer: item types, codes and defaults.
package txcw_pkg;

  // Default screen geometry
  localparam int unsigned ROWS_DEF = 25;
  localparam int unsigned COLS_DEF = 80;

  // Fixed field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned CELL_W = 16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BS    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
  localparam logic [7:0]        ATTR_RESET   = 8'h0F;

  // Configuration registers
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_FG    = 1'b0;
  localparam logic        REG_BG    = 1'b1;
  localparam logic [3:0]  FG_RESET  = 4'hF;
  localparam logic [3:0]  BG_RESET  = 4'h0;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [7:0]        cell_attr;
  } out_item_t;

endpackage

/* rtl/txcw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module txcw_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/text_console_writer.sv */
// Text console writer top level: cursor control, scroll and clear sequencer, screen store.
//
// A ROWS x COLS character-cell console. Each cell of the screen store holds
// {attribute, character}; the attribute is {bg_color, fg_color} from the APB
// registers. Put-char and backspace write their cell at the edge the input
// beat is accepted; for these and for a newline without a scroll the result
// beat sits in the output register from the next cycle. A read goes through
// the registered read port of the screen memory and then the output register.
// A put or newline that runs off the bottom row scrolls: the copy pass reads
// one cell and writes one cell per cycle, then the bottom row is blanked.
// Clear sweeps the whole store. After reset a clearing pass loads every cell
// with space on attribute 0x0F; no input beat is accepted until it is done,
// while APB writes are taken throughout. One item is in flight at a time; the
// next beat is taken as soon as the sequencer is idle and the output register
// is empty or being emptied.
module text_console_writer #(
  parameter int unsigned ROWS = txcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = txcw_pkg::COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  txcw_pkg::in_item_t            in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output txcw_pkg::out_item_t           out_data_o,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [txcw_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned NCELLS = ROWS * COLS;
  localparam int unsigned AW     = $clog2(NCELLS);       // memory index
  localparam int unsigned CNTW   = $clog2(NCELLS + 1);   // can hold NCELLS itself
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned CW     = $clog2(COLS);
  localparam int unsigned EXW    = ((AW > txcw_pkg::ADDR_W) ? AW : txcw_pkg::ADDR_W) + 1;

  localparam logic [CNTW-1:0] NC_C      = CNTW'(NCELLS);
  localparam logic [CNTW-1:0] NC_M1     = CNTW'(NCELLS - 1);
  localparam logic [CNTW-1:0] COLS_C    = CNTW'(COLS);
  localparam logic [CNTW-1:0] LAST_ROW0 = CNTW'(NCELLS - COLS);
  localparam logic [RW-1:0]   ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]   COL_LAST  = CW'(COLS - 1);

  // sequencer states
  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] pos_q, pos_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  logic [txcw_pkg::CELL_W-1:0] fill_q, fill_d;
  logic            res_pend_q, res_pend_d;
  logic            rd_ok_q, rd_ok_d;
  logic            cp_v_q, cp_v_d;
  logic [AW-1:0]   cp_wa_q, cp_wa_d;
  logic [3:0]      fg_q, bg_q;
  logic            out_valid_q, out_valid_d;
  txcw_pkg::out_item_t out_q, out_d;

  logic            in_fire, out_fire, cfg_wr;
  logic [7:0]      attr;
  logic [txcw_pkg::CELL_W-1:0] blank;
  logic            is_nl, scroll;
  logic [EXW-1:0]  rd_addr_ext, pos_ext, pos_d_ext;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [txcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  assign attr  = {bg_q, fg_q};
  assign blank = {attr, txcw_pkg::CHAR_BLANK};

  // ---------------------------------------------------------------------------
  // APB registers
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= txcw_pkg::FG_RESET;
      bg_q <= txcw_pkg::BG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        txcw_pkg::REG_FG: fg_q <= pwdata[3:0];
        txcw_pkg::REG_BG: bg_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      txcw_pkg::REG_FG: prdata = {28'd0, fg_q};
      txcw_pkg::REG_BG: prdata = {28'd0, bg_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address checks
  // ---------------------------------------------------------------------------
  assign rd_addr_ext = EXW'(in_data_i.address);
  assign pos_ext     = EXW'(pos_q);
  assign pos_d_ext   = EXW'(pos_d);
  assign is_nl       = (in_data_i.char_code == txcw_pkg::CHAR_NEWLINE);

  // Put or newline that runs off the bottom row
  assign scroll = (row_q == ROW_LAST) && (is_nl || (col_q == COL_LAST));

  // ---------------------------------------------------------------------------
  // Sequencer and cursor
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    fill_d      = fill_q;
    res_pend_d  = res_pend_q;
    rd_ok_d     = rd_ok_q;
    cp_v_d      = 1'b0;
    cp_wa_d     = cp_wa_q;
    out_valid_d = out_valid_q && !out_fire;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.action)
            txcw_pkg::ACT_PUT: begin
              if (scroll) begin
                row_d      = ROW_LAST;
                col_d      = '0;
                pos_d      = LAST_ROW0;
                fill_d     = blank;
                res_pend_d = 1'b1;
                cnt_d      = COLS_C;
                state_d    = ST_COPY;
              end else if (is_nl) begin
                row_d = row_q + 1'b1;
                col_d = '0;
                pos_d = pos_q - CNTW'(col_q) + COLS_C;
              end else if (col_q == COL_LAST) begin
                row_d = row_q + 1'b1;
                col_d = '0;
                pos_d = pos_q + 1'b1;
              end else begin
                col_d = col_q + 1'b1;
                pos_d = pos_q + 1'b1;
              end
            end
            txcw_pkg::ACT_BS: begin
              if (pos_q != '0) begin
                pos_d = pos_q - 1'b1;
                if (col_q == '0) begin
                  col_d = COL_LAST;
                  row_d = row_q - 1'b1;
                end else begin
                  col_d = col_q - 1'b1;
                end
              end
            end
            txcw_pkg::ACT_CLEAR: begin
              row_d      = '0;
              col_d      = '0;
              pos_d      = '0;
              fill_d     = blank;
              res_pend_d = 1'b1;
              cnt_d      = '0;
              state_d    = ST_FILL;
            end
            txcw_pkg::ACT_READ: begin
              rd_ok_d = (rd_addr_ext < EXW'(NCELLS));
              state_d = ST_READ;
            end
            default: ;
          endcase
          // backspace and puts without a scroll report straight away
          if ((in_data_i.action == txcw_pkg::ACT_BS) ||
              ((in_data_i.action == txcw_pkg::ACT_PUT) && !scroll)) begin
            out_valid_d = 1'b1;
            out_d.cursor_pos = pos_d_ext[txcw_pkg::ADDR_W-1:0];
            out_d.cell_char  = '0;
            out_d.cell_attr  = '0;
          end
        end
      end
      ST_READ: begin
        out_valid_d      = 1'b1;
        out_d.cursor_pos = pos_ext[txcw_pkg::ADDR_W-1:0];
        out_d.cell_char  = rd_ok_q ? ram_rdata[7:0]  : 8'd0;
        out_d.cell_attr  = rd_ok_q ? ram_rdata[15:8] : 8'd0;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        // read cell cnt, write it one row up on the next cycle
        if (cnt_q != NC_C) begin
          cp_v_d  = 1'b1;
          cp_wa_d = AW'(cnt_q - COLS_C);
          cnt_d   = cnt_q + 1'b1;
        end else begin
          cnt_d   = LAST_ROW0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == NC_M1) begin
          state_d = ST_IDLE;
          if (res_pend_q) begin
            res_pend_d       = 1'b0;
            out_valid_d      = 1'b1;
            out_d.cursor_pos = pos_ext[txcw_pkg::ADDR_W-1:0];
            out_d.cell_char  = '0;
            out_d.cell_attr  = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Screen store ports
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q[AW-1:0];
    ram_wdata = blank;
    if (cp_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_wa_q;
      ram_wdata = ram_rdata;
    end else if (state_q == ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = fill_q;
    end else if (in_fire && (in_data_i.action == txcw_pkg::ACT_PUT) && !is_nl) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q[AW-1:0];
      ram_wdata = {attr, in_data_i.char_code};
    end else if (in_fire && (in_data_i.action == txcw_pkg::ACT_BS)) begin
      ram_we    = 1'b1;
      ram_waddr = pos_d[AW-1:0];
      ram_wdata = blank;
    end
  end

  assign ram_raddr = (state_q == ST_COPY) ? cnt_q[AW-1:0] : rd_addr_ext[AW-1:0];

  txcw_ram #(
    .WIDTH (txcw_pkg::CELL_W),
    .DEPTH (NCELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;            // clearing pass after reset
      cnt_q       <= '0;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      fill_q      <= {txcw_pkg::ATTR_RESET, txcw_pkg::CHAR_BLANK};
      res_pend_q  <= 1'b0;
      cp_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      fill_q      <= fill_d;
      res_pend_q  <= res_pend_d;
      cp_v_q      <= cp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    cp_wa_q <= cp_wa_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
